@@ rtl/core/pglide_pkg.sv @@
// Shared types, widths and codes for the portamento glide core.
package pglide_pkg;

   // value format: signed, 24 fractional bits
   localparam int VALUE_W = 40;
   localparam int NOTE_W = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int MODE_W = 2;

   // linear step drops the low 8 of its 32 fractional bits
   localparam int STEP_DROP = 8;
   localparam int STEP_W = CSR_DATA_W - STEP_DROP;

   // serial multiplier: mag = floor(a * a * c / 2^PROD_SHIFT)
   localparam int A_W = VALUE_W + 1;
   localparam int C_W = CSR_DATA_W;
   localparam int T_W = A_W + C_W;
   localparam int T3_W = T_W + 2;
   localparam int DIGIT_W = 2;
   localparam int DIGITS_AC = C_W / DIGIT_W;
   localparam int DIGITS_TA = (A_W + DIGIT_W - 1) / DIGIT_W;
   localparam int MULT_W = DIGITS_TA * DIGIT_W;
   localparam int CNT_W = 5;
   localparam int PROD_SHIFT = 56;
   localparam int MAG_LSB = PROD_SHIFT - MULT_W;
   localparam int MAG_W = 58;
   localparam int SUM_W = MAG_W + 2;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GLIDE_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_RATE = 2'd2;

   // glide mode codes; the unused code behaves as always glide
   localparam logic [MODE_W-1:0] GLIDE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] GLIDE_AUTO = 2'd1;
   localparam logic [MODE_W-1:0] GLIDE_ALWAYS = 2'd2;

   typedef enum logic [2:0] {
      CTRL_IDLE,
      CTRL_PREP,
      CTRL_DIFF,
      CTRL_MUL,
      CTRL_SUM,
      CTRL_OUT
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_TRIPLE,
      MUL_RUN
   } mul_state_type;

endpackage

@@ rtl/core/pglide_mul.sv @@
// Radix-4 shift-add multiplier computing floor(a * a * c / 2^56) in two passes.
module pglide_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pglide_pkg::A_W-1:0]     a,
   input  logic [pglide_pkg::C_W-1:0]     c,
   output logic                           done,
   output logic [pglide_pkg::MAG_W-1:0]   mag
);
   import pglide_pkg::*;

   mul_state_type      state_ff, state_in;
   logic               phase_ff, phase_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [T_W-1:0]     acc_ff, acc_in;
   logic [MULT_W-1:0]  mult_ff, mult_in;
   logic [T_W-1:0]     mcand_ff, mcand_in;
   logic [T3_W-1:0]    mcand3_ff, mcand3_in;

   logic [T3_W-1:0]    addend;
   logic [T3_W-1:0]    sum;
   logic [CNT_W-1:0]   last_cnt;

   always_comb begin
      case (mult_ff[DIGIT_W-1:0])
         2'd0: addend = '0;
         2'd1: addend = {2'b00, mcand_ff};
         2'd2: addend = {1'b0, mcand_ff, 1'b0};
         2'd3: addend = mcand3_ff;
         default: addend = '0;
      endcase
      sum = {2'b00, acc_ff} + addend;
      last_cnt = phase_ff ? CNT_W'(DIGITS_TA - 1) : CNT_W'(DIGITS_AC - 1);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      mult_in = mult_ff;
      mcand_in = mcand_ff;
      mcand3_in = mcand3_ff;
      case (state_ff)
         MUL_IDLE: begin
            if (start) begin
               // first pass: t = a * c
               mcand_in = {{(T_W-A_W){1'b0}}, a};
               mult_in = {{(MULT_W-C_W){1'b0}}, c};
               acc_in = '0;
               phase_in = 1'b0;
               state_in = MUL_TRIPLE;
            end
         end
         MUL_TRIPLE: begin
            mcand3_in = {2'b00, mcand_ff} + {1'b0, mcand_ff, 1'b0};
            cnt_in = '0;
            state_in = MUL_RUN;
         end
         MUL_RUN: begin
            // add one digit's multiple, then shift product and multiplier right
            acc_in = sum[T3_W-1:DIGIT_W];
            mult_in = {sum[DIGIT_W-1:0], mult_ff[MULT_W-1:DIGIT_W]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == last_cnt) begin
               if (!phase_ff) begin
                  // second pass: mag = (t * a) >> 56, low product bits drop out
                  mcand_in = {acc_in[A_W-1:0], mult_in[MULT_W-1:MULT_W-C_W]};
                  mult_in = {{(MULT_W-A_W){1'b0}}, mcand_ff[A_W-1:0]};
                  acc_in = '0;
                  phase_in = 1'b1;
                  state_in = MUL_TRIPLE;
               end else begin
                  done_in = 1'b1;
                  state_in = MUL_IDLE;
               end
            end
         end
         default: state_in = MUL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      mult_ff <= mult_in;
      mcand_ff <= mcand_in;
      mcand3_ff <= mcand3_in;
   end

   assign done = done_ff;
   assign mag = acc_ff[MAG_LSB +: MAG_W];

endmodule

@@ rtl/core/portamento_glide_core.sv @@
// Portamento glide core: linear step, clamp, quadratic pull and saturation per item in
// glide modes; off mode passes the target straight through. Most of a glide item is the
// radix-4 multiplier (16 digits for a*c, 21 digits for that times a). A new item is
// taken only when idle, after the last result is registered. A stalled result holds the
// next item in the sequencer until the output register frees up.
// Synchronous reset clears the held value, all configuration registers and the handshake.
module portamento_glide_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [pglide_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pglide_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pglide_pkg::VALUE_W-1:0]  req_target,
   input  logic                                   req_jump_event,
   input  logic                                   req_start_event,
   input  logic signed [pglide_pkg::VALUE_W-1:0]  req_start_value,
   input  logic [pglide_pkg::NOTE_W-1:0]          req_note_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pglide_pkg::VALUE_W-1:0]  rsp_value
);
   import pglide_pkg::*;

   ctrl_state_type              state_ff, state_in;
   logic [MODE_W-1:0]           glide_type_ff;
   logic [CSR_DATA_W-1:0]       step_size_ff;
   logic [CSR_DATA_W-1:0]       curve_rate_ff;
   logic signed [VALUE_W-1:0]   held_ff, held_in;
   logic signed [VALUE_W-1:0]   target_ff, target_in;
   logic                        neg_ff, neg_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;

   logic                        mul_start;
   logic                        mul_done;
   logic [MAG_W-1:0]            mul_mag;

   logic signed [VALUE_W+1:0]   held_x, target_x, step_x, down, up;
   logic signed [VALUE_W-1:0]   stepped;
   logic signed [VALUE_W:0]     diff;
   logic                        diff_neg;
   logic [A_W-1:0]              gap_mag;
   logic signed [SUM_W-1:0]     held_s, mag_s, total;
   logic signed [VALUE_W-1:0]   saturated;
   logic                        snap;

   // linear step toward the target, clamped so it does not pass it
   always_comb begin
      held_x = (VALUE_W+2)'(held_ff);
      target_x = (VALUE_W+2)'(target_ff);
      step_x = signed'({{(VALUE_W+2-STEP_W){1'b0}}, step_size_ff[CSR_DATA_W-1:STEP_DROP]});
      down = held_x - step_x;
      up = held_x + step_x;
      if (target_ff <= held_ff) begin
         stepped = (down < target_x) ? target_ff : down[VALUE_W-1:0];
      end else begin
         stepped = (up > target_x) ? target_ff : up[VALUE_W-1:0];
      end
   end

   // remaining distance and its magnitude
   always_comb begin
      diff = (VALUE_W+1)'(target_ff) - (VALUE_W+1)'(held_ff);
      diff_neg = diff[VALUE_W];
      gap_mag = diff_neg ? A_W'(-diff) : A_W'(diff);
   end

   // apply the quadratic pull and saturate to the value range
   always_comb begin
      held_s = SUM_W'(held_ff);
      mag_s = signed'({2'b00, mul_mag});
      total = neg_ff ? (held_s - mag_s) : (held_s + mag_s);
      if (total > SUM_W'(VALUE_MAX)) begin
         saturated = VALUE_MAX;
      end else if (total < SUM_W'(VALUE_MIN)) begin
         saturated = VALUE_MIN;
      end else begin
         saturated = total[VALUE_W-1:0];
      end
   end

   assign snap = (glide_type_ff == GLIDE_AUTO) && req_jump_event
                 && (req_note_count <= NOTE_W'(1));

   always_comb begin
      state_in = state_ff;
      held_in = held_ff;
      target_in = target_ff;
      neg_in = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      mul_start = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            if (req_valid) begin
               target_in = req_target;
               if (glide_type_ff == GLIDE_OFF) begin
                  held_in = req_target;
                  state_in = CTRL_OUT;
               end else begin
                  if (snap) begin
                     held_in = req_target;
                  end else if (req_start_event) begin
                     held_in = req_start_value;
                  end
                  state_in = CTRL_PREP;
               end
            end
         end
         CTRL_PREP: begin
            held_in = stepped;
            state_in = CTRL_DIFF;
         end
         CTRL_DIFF: begin
            neg_in = diff_neg;
            mul_start = 1'b1;
            state_in = CTRL_MUL;
         end
         CTRL_MUL: begin
            if (mul_done) begin
               state_in = CTRL_SUM;
            end
         end
         CTRL_SUM: begin
            held_in = saturated;
            state_in = CTRL_OUT;
         end
         CTRL_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = held_ff;
               state_in = CTRL_IDLE;
            end
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
         held_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glide_type_ff <= GLIDE_OFF;
         step_size_ff <= '0;
         curve_rate_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GLIDE_TYPE: glide_type_ff <= csr_data[MODE_W-1:0];
            CSR_STEP_SIZE: step_size_ff <= csr_data;
            CSR_CURVE_RATE: curve_rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      neg_ff <= neg_in;
      rsp_value_ff <= rsp_value_in;
   end

   pglide_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (gap_mag),
      .c     (curve_rate_ff),
      .done  (mul_done),
      .mag   (mul_mag)
   );

   assign req_stall = (state_ff != CTRL_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

@@ tb/glide_checker.sv @@
`timescale 1ns / 1ps
// Checker for the portamento glide core: predicts every glided value and compares results.
module glide_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_en,
   input  logic [pglide_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pglide_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic                                   req_valid,
   input  logic                                   req_stall,
   input  logic signed [pglide_pkg::VALUE_W-1:0]  req_target,
   input  logic                                   req_jump_event,
   input  logic                                   req_start_event,
   input  logic signed [pglide_pkg::VALUE_W-1:0]  req_start_value,
   input  logic [pglide_pkg::NOTE_W-1:0]          req_note_count,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   input  logic signed [pglide_pkg::VALUE_W-1:0]  rsp_value,
   output int                                     errors,
   output int                                     outstanding
);
   import pglide_pkg::*;

   logic [MODE_W-1:0]         glide_mode;
   logic [CSR_DATA_W-1:0]     linear_step;
   logic [CSR_DATA_W-1:0]     curve_pull;
   logic signed [VALUE_W-1:0] glide_level;
   logic signed [VALUE_W-1:0] oldest_value;
   logic signed [VALUE_W-1:0] expected_values[$];

   function automatic logic signed [VALUE_W-1:0] next_glide_value(
      input logic signed [VALUE_W-1:0] target,
      input logic                      jump,
      input logic                      start,
      input logic signed [VALUE_W-1:0] load_value,
      input logic [NOTE_W-1:0]         notes
   );
      longint goal;
      longint level;
      longint stride;
      longint gap;
      longint pull_mag;
      logic [127:0] dist_abs;
      logic [127:0] pull;
      if (glide_mode == GLIDE_OFF)
         return target;
      goal = target;
      level = glide_level;
      // snap only in auto mode on the first note; otherwise a start loads
      if (glide_mode == GLIDE_AUTO && jump && notes <= 1)
         level = goal;
      else if (start)
         level = load_value;
      stride = linear_step >> STEP_DROP;
      if (goal <= level) begin
         level = level - stride;
         if (level < goal)
            level = goal;
      end else begin
         level = level + stride;
         if (level > goal)
            level = goal;
      end
      gap = goal - level;
      dist_abs = 128'((gap < 0) ? -gap : gap);
      pull = dist_abs * dist_abs * curve_pull;
      pull_mag = longint'(pull >> PROD_SHIFT);
      // the pull may overshoot the target; only the value range limits it
      level = (gap < 0) ? level - pull_mag : level + pull_mag;
      if (level > longint'(VALUE_MAX))
         level = longint'(VALUE_MAX);
      if (level < longint'(VALUE_MIN))
         level = longint'(VALUE_MIN);
      return level[VALUE_W-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         glide_mode = GLIDE_OFF;
         linear_step = '0;
         curve_pull = '0;
         glide_level = '0;
         expected_values.delete();
         errors <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_GLIDE_TYPE: glide_mode = csr_data[MODE_W-1:0];
               CSR_STEP_SIZE: linear_step = csr_data;
               CSR_CURVE_RATE: curve_pull = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            glide_level = next_glide_value(req_target, req_jump_event, req_start_event,
                                           req_start_value, req_note_count);
            expected_values.push_back(glide_level);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_values.size() == 0) begin
               $display("%0t unexpected glide value: expected none, actual %0d",
                        $time, rsp_value);
               errors <= errors + 1;
            end else begin
               oldest_value = expected_values.pop_front();
               if (rsp_value !== oldest_value) begin
                  $display("%0t glide value mismatch: expected %0d, actual %0d",
                           $time, oldest_value, rsp_value);
                  errors <= errors + 1;
               end
            end
         end
      end
      outstanding <= expected_values.size();
   end

endmodule

@@ tb/tb_portamento_glide_core.sv @@
`timescale 1ns / 1ps
// Testbench top for the portamento glide core: drives settings and items, gives the verdict.
module tb_portamento_glide_core;
   import pglide_pkg::*;

   localparam logic [MODE_W-1:0] GLIDE_SPARE = 2'd3;
   localparam int IDLE_PCT = 17;
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_ROUND = 2;
   localparam int CALM_ROUND = 6;
   localparam int RANDOM_ROUNDS = 16;
   localparam int ROUND_ITEMS = 100;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT = 600000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_GLIDE_TYPE;
   logic [CSR_DATA_W-1:0]     csr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_target = '0;
   logic                      req_jump_event = 1'b0;
   logic                      req_start_event = 1'b0;
   logic signed [VALUE_W-1:0] req_start_value = '0;
   logic [NOTE_W-1:0]         req_note_count = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_value;

   int fail_count;
   int pending_items;
   bit calm = 1'b0;
   bit hold_request = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;
   logic signed [VALUE_W-1:0] note_target = '0;

   portamento_glide_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_target      (req_target),
      .req_jump_event  (req_jump_event),
      .req_start_event (req_start_event),
      .req_start_value (req_start_value),
      .req_note_count  (req_note_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value)
   );

   glide_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_target      (req_target),
      .req_jump_event  (req_jump_event),
      .req_start_event (req_start_event),
      .req_start_value (req_start_value),
      .req_note_count  (req_note_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .errors          (fail_count),
      .outstanding     (pending_items)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // result side: random stalls, one long hold-off so the core backs up
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   function automatic logic signed [VALUE_W-1:0] random_value();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[VALUE_W-1:0];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return '1;
      else if (pick == 2)
         return $urandom;
      return $urandom >> $urandom_range(8, 31);
   endfunction

   function automatic logic [MODE_W-1:0] random_mode();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         return GLIDE_OFF;
      else if (pick < 45)
         return GLIDE_AUTO;
      else if (pick < 85)
         return GLIDE_ALWAYS;
      return GLIDE_SPARE;
   endfunction

   // write all three registers back to back; the core must be idle
   task automatic program_regs(input logic [MODE_W-1:0] mode,
                               input logic [CSR_DATA_W-1:0] stride,
                               input logic [CSR_DATA_W-1:0] pull);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      csr_write_en <= 1'b1;
      csr_index <= CSR_GLIDE_TYPE;
      csr_data <= {junk[CSR_DATA_W-1:MODE_W], mode};
      @(posedge clock);
      csr_index <= CSR_STEP_SIZE;
      csr_data <= stride;
      @(posedge clock);
      csr_index <= CSR_CURVE_RATE;
      csr_data <= pull;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic send_item(input logic signed [VALUE_W-1:0] target,
                            input logic jump,
                            input logic start,
                            input logic signed [VALUE_W-1:0] load_value,
                            input logic [NOTE_W-1:0] notes);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(9, 60) : $urandom_range(1, 8))
            @(posedge clock);
      end
      req_valid <= 1'b1;
      req_target <= target;
      req_jump_event <= jump;
      req_start_event <= start;
      req_start_value <= load_value;
      req_note_count <= notes;
      do @(posedge clock); while (req_stall);
   endtask

   // held notes with occasional note changes, jumps and start loads
   task automatic send_random();
      int pick;
      logic signed [VALUE_W-1:0] load_value;
      logic [NOTE_W-1:0] notes;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         note_target = random_value();
      else if (pick < 20)
         note_target = VALUE_W'($signed($urandom));
      else if (pick < 22)
         note_target = VALUE_MAX;
      else if (pick < 24)
         note_target = VALUE_MIN;
      load_value = ($urandom_range(0, 1) == 0) ? random_value()
                                                : VALUE_W'($signed($urandom));
      notes = NOTE_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(0, 2));
      send_item(note_target, $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 10,
                load_value, notes);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_items != 0);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // off mode follows the target and ignores events
      program_regs(GLIDE_OFF, '0, '0);
      send_item(VALUE_MIN, 1'b1, 1'b1, VALUE_MAX, 7'd0);
      send_item(VALUE_MAX, 1'b0, 1'b1, VALUE_MIN, 7'd127);
      send_item('0, 1'b1, 1'b0, '0, 7'd1);
      drain();

      // widest step and pull: saturate at both ends, sit on the target
      program_regs(GLIDE_ALWAYS, '1, '1);
      send_item(VALUE_MAX, 1'b0, 1'b1, VALUE_MIN, 7'd5);
      send_item(VALUE_MIN, 1'b0, 1'b1, VALUE_MAX, 7'd5);
      send_item(VALUE_MIN, 1'b0, 1'b0, '0, 7'd5);
      send_item(40'sd1000, 1'b0, 1'b0, '0, 7'd5);
      send_item(-40'sd1000, 1'b1, 1'b0, '0, 7'd0);
      drain();

      // auto snap on first note, jump against start
      program_regs(GLIDE_AUTO, 32'h0010_0000, 32'h0000_1000);
      send_item(40'sd50000000, 1'b1, 1'b0, '0, 7'd0);
      send_item(-40'sd50000000, 1'b1, 1'b0, '0, 7'd1);
      send_item(40'sd50000000, 1'b1, 1'b0, '0, 7'd2);
      send_item(40'sd50000000, 1'b1, 1'b0, '0, 7'd127);
      send_item(40'sd80000000, 1'b1, 1'b1, 40'sd7, 7'd0);
      send_item(40'sd80000000, 1'b1, 1'b1, -40'sd7, 7'd3);
      send_item(-40'sd9000000, 1'b0, 1'b1, 40'sd123456789, 7'd0);
      send_item(-40'sd9000000, 1'b0, 1'b0, '0, 7'd0);
      drain();

      // spare mode code glides like always: no snap, no motion with zero rates
      program_regs(GLIDE_SPARE, '0, '0);
      send_item(VALUE_MAX, 1'b1, 1'b0, '0, 7'd0);
      send_item(VALUE_MAX, 1'b0, 1'b1, -40'sd5, 7'd0);
      send_item(VALUE_MIN, 1'b0, 1'b0, '0, 7'd0);
      drain();

      // pull alone overshoots the target
      program_regs(GLIDE_ALWAYS, '0, '1);
      send_item(40'sd67108864, 1'b0, 1'b1, '0, 7'd0);
      send_item(40'sd67108864, 1'b0, 1'b0, '0, 7'd0);
      drain();

      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         program_regs(random_mode(), random_word(), random_word());
         calm = (round == CALM_ROUND);
         if (round == HOLD_ROUND)
            hold_request = 1'b1;
         for (int n = 0; n < ROUND_ITEMS; n++)
            send_random();
         drain();
      end
      calm = 1'b0;

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/pglide_pkg.sv
rtl/core/pglide_mul.sv
rtl/core/portamento_glide_core.sv
tb/glide_checker.sv
tb/tb_portamento_glide_core.sv
